// ===== rtl/itoa_pkg.sv =====
// Shared types and constants for the integer to ASCII converter.
`timescale 1ns / 1ps
package itoa_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned BaseW   = 5;
  localparam int unsigned CharW   = 8;
  localparam int unsigned BcdW    = 40;
  localparam int unsigned NumDig  = 32;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned DdStages = 4;
  localparam int unsigned DdSteps  = 8;

  localparam logic [BaseW-1:0] RADIX_BIN = 5'd2;
  localparam logic [BaseW-1:0] RADIX_OCT = 5'd8;
  localparam logic [BaseW-1:0] RADIX_DEC = 5'd10;
  localparam logic [BaseW-1:0] RADIX_HEX = 5'd16;

  localparam logic [CharW-1:0] CH_DIGIT  = 8'h30;
  localparam logic [CharW-1:0] CH_LETTER = 8'h37;
  localparam logic [CharW-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CharW-1:0] CH_NULL   = 8'h00;

  typedef enum logic [1:0] {
    BASE_2  = 2'd0,
    BASE_8  = 2'd1,
    BASE_10 = 2'd2,
    BASE_16 = 2'd3
  } base_e;

  // Request moving through the conversion stages.
  typedef struct packed {
    logic [ValueW-1:0] raw;
    logic [ValueW-1:0] sh;
    logic [BcdW-1:0]   bcd;
    base_e             base;
    logic              neg;
    logic              bad;
  } pipe_t;

  // Request after digit extraction, digits least significant first.
  typedef struct packed {
    logic [NumDig-1:0][3:0] digits;
    logic [IdxW-1:0]        top;
    logic                   neg;
    logic                   bad;
  } dig_t;

endpackage

// ===== rtl/itoa_front.sv =====
// Input stage: decode the radix and form the magnitude.
`timescale 1ns / 1ps
module itoa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [itoa_pkg::ValueW-1:0]   value_i,
  input  logic [itoa_pkg::BaseW-1:0]    base_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output itoa_pkg::pipe_t               data_o
);

  logic            valid_q;
  itoa_pkg::pipe_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d     = '0;
    data_d.raw = value_i;
    data_d.sh  = value_i;
    unique case (base_i)
      itoa_pkg::RADIX_BIN: data_d.base = itoa_pkg::BASE_2;
      itoa_pkg::RADIX_OCT: data_d.base = itoa_pkg::BASE_8;
      itoa_pkg::RADIX_HEX: data_d.base = itoa_pkg::BASE_16;
      itoa_pkg::RADIX_DEC: begin
        data_d.base = itoa_pkg::BASE_10;
        if (value_i[itoa_pkg::ValueW-1]) begin
          data_d.neg = 1'b1;
          data_d.sh  = '0 - value_i;
        end
      end
      default: begin
        data_d.base = itoa_pkg::BASE_2;
        data_d.bad  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/itoa_dabble.sv =====
// One registered slice of the binary to BCD shift-add-3 conversion.
`timescale 1ns / 1ps
module itoa_dabble (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  itoa_pkg::pipe_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output itoa_pkg::pipe_t data_o
);

  localparam int unsigned BcdDig = itoa_pkg::BcdW / 4;

  logic            valid_q;
  itoa_pkg::pipe_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Adjust every BCD digit at five or more, then shift the next bit in.
  always_comb begin
    data_d = data_i;
    for (int s = 0; s < itoa_pkg::DdSteps; s++) begin
      for (int d = 0; d < BcdDig; d++) begin
        if (data_d.bcd[4*d +: 4] >= 4'd5) begin
          data_d.bcd[4*d +: 4] = data_d.bcd[4*d +: 4] + 4'd3;
        end
      end
      data_d.bcd = {data_d.bcd[itoa_pkg::BcdW-2:0], data_d.sh[itoa_pkg::ValueW-1]};
      data_d.sh  = {data_d.sh[itoa_pkg::ValueW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/itoa_digits.sv =====
// Digit extraction per radix and top-digit search.
`timescale 1ns / 1ps
module itoa_digits (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  itoa_pkg::pipe_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output itoa_pkg::dig_t  data_o
);

  localparam int unsigned OctTop = itoa_pkg::ValueW / 3;
  localparam int unsigned HexDig = itoa_pkg::ValueW / 4;
  localparam int unsigned BcdDig = itoa_pkg::BcdW / 4;

  logic                          valid_q;
  itoa_pkg::dig_t                data_q, data_d;
  logic [itoa_pkg::NumDig-1:0]   nz;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d     = '0;
    data_d.neg = data_i.neg;
    data_d.bad = data_i.bad;
    case (data_i.base)
      itoa_pkg::BASE_2: begin
        for (int i = 0; i < itoa_pkg::NumDig; i++) begin
          data_d.digits[i] = {3'b000, data_i.raw[i]};
        end
      end
      itoa_pkg::BASE_8: begin
        for (int i = 0; i < OctTop; i++) begin
          data_d.digits[i] = {1'b0, data_i.raw[3*i +: 3]};
        end
        // top octal digit holds the two leftover bits, unsigned
        data_d.digits[OctTop] = {2'b00, data_i.raw[itoa_pkg::ValueW-1 -: 2]};
      end
      itoa_pkg::BASE_10: begin
        for (int i = 0; i < BcdDig; i++) begin
          data_d.digits[i] = data_i.bcd[4*i +: 4];
        end
      end
      default: begin
        for (int i = 0; i < HexDig; i++) begin
          data_d.digits[i] = data_i.raw[4*i +: 4];
        end
      end
    endcase
    if (data_i.bad) begin
      data_d.digits = '0;
    end
    for (int i = 0; i < itoa_pkg::NumDig; i++) begin
      nz[i] = (data_d.digits[i] != 4'd0);
    end
    // highest nonzero digit; zero prints as a single digit
    for (int i = 0; i < itoa_pkg::NumDig; i++) begin
      if (nz[i]) begin
        data_d.top = i[itoa_pkg::IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/itoa_serial.sv =====
// Character serializer with registered output.
`timescale 1ns / 1ps
module itoa_serial (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  itoa_pkg::dig_t              data_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [itoa_pkg::CharW-1:0]  m_char_o,
  output logic                        m_last_o,
  output logic                        m_bad_o
);

  logic                            busy_q, busy_d;
  logic                            minus_q, minus_d;
  logic                            bad_q, bad_d;
  logic [itoa_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [itoa_pkg::NumDig-1:0][3:0] dig_q, dig_d;
  logic                            ovalid_q, ovalid_d;
  logic [itoa_pkg::CharW-1:0]      char_q, char_d;
  logic                            last_q, last_d;
  logic                            obad_q, obad_d;
  logic                            can_load;
  logic                            finishing;
  logic [3:0]                      cur;

  assign can_load  = !ovalid_q || m_ready_i;
  assign finishing = busy_q && can_load && !minus_q && (idx_q == '0);
  assign ready_o   = !busy_q || finishing;
  assign cur       = dig_q[idx_q];

  assign m_valid_o = ovalid_q;
  assign m_char_o  = char_q;
  assign m_last_o  = last_q;
  assign m_bad_o   = obad_q;

  always_comb begin
    busy_d   = busy_q;
    minus_d  = minus_q;
    bad_d    = bad_q;
    idx_d    = idx_q;
    dig_d    = dig_q;
    ovalid_d = ovalid_q;
    char_d   = char_q;
    last_d   = last_q;
    obad_d   = obad_q;
    if (can_load) begin
      ovalid_d = busy_q;
      if (busy_q) begin
        obad_d = bad_q;
        if (minus_q) begin
          char_d  = itoa_pkg::CH_MINUS;
          last_d  = 1'b0;
          minus_d = 1'b0;
        end else begin
          if (bad_q) begin
            char_d = itoa_pkg::CH_NULL;
          end else if (cur <= 4'd9) begin
            char_d = itoa_pkg::CH_DIGIT + {4'b0000, cur};
          end else begin
            char_d = itoa_pkg::CH_LETTER + {4'b0000, cur};
          end
          last_d = (idx_q == '0);
          idx_d  = idx_q - 1'b1;
          if (idx_q == '0) begin
            busy_d = 1'b0;
          end
        end
      end
    end
    if (valid_i && ready_o) begin
      busy_d  = 1'b1;
      minus_d = data_i.neg;
      bad_d   = data_i.bad;
      idx_d   = data_i.top;
      dig_d   = data_i.digits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      minus_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      minus_q  <= minus_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q  <= bad_d;
    idx_q  <= idx_d;
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
    obad_q <= obad_d;
  end

`ifndef SYNTHESIS
  // an error result is always a single, final, null character
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && obad_q |-> last_q && (char_q == itoa_pkg::CH_NULL))
    else $error("error result not final or not null");

  // the sign never closes a conversion
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && (char_q == itoa_pkg::CH_MINUS) |-> !last_q)
    else $error("minus sign marked last");

  // characters of one conversion follow without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && m_ready_i && !last_q |=> ovalid_q)
    else $error("gap inside a conversion");

  // a new request is taken only when the current one has ended
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && busy_q |-> can_load && !minus_q && (idx_q == '0))
    else $error("request loaded over an unfinished one");
`endif

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
// Top level of the integer to ASCII converter.
`timescale 1ns / 1ps
// Converts a 32-bit value to ASCII in base 2, 8, 10 or 16 and streams the
// characters out one per beat, most significant first, no leading zeros,
// tlast on the final character. Bases 2, 8 and 16 print the raw bit pattern
// unsigned with upper-case hex; base 10 is signed with a leading '-'. Any
// other base yields one beat with char 0, tlast and tuser (error) set.
// A request passes eight register stages: radix decode, four BCD slices
// of eight shift steps each, digit extraction, the serializer's digit
// register, then its output register.
// Requests are accepted back to back into the pipeline; the output port
// moves one character per cycle while tready is high; a conversion of N
// characters (1 to 32, at most 11 for base 10) holds the serializer until
// its end, which sets the sustained rate. No clearing or setup after reset.
module integer_to_ascii_radix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // value[31:0], base[36:32], zero fill
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // char_out[7:0]
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // bad_base[0]
);

  localparam int unsigned NStg = itoa_pkg::DdStages;

  // front stage outputs
  logic            fr_valid, fr_ready;
  itoa_pkg::pipe_t fr_data;

  // BCD slice chain, index 0 is the front stage output
  logic            dd_valid [NStg+1];
  logic            dd_ready [NStg+1];
  itoa_pkg::pipe_t dd_data  [NStg+1];

  logic            dg_valid, dg_ready;
  itoa_pkg::dig_t  dg_data;

  itoa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .value_i (s_axis_tdata_i[itoa_pkg::ValueW-1:0]),
    .base_i  (s_axis_tdata_i[itoa_pkg::ValueW +: itoa_pkg::BaseW]),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .data_o  (fr_data)
  );

  assign dd_valid[0] = fr_valid;
  assign dd_data[0]  = fr_data;
  assign fr_ready    = dd_ready[0];

  // each slice advances the BCD conversion by eight bits
  for (genvar g = 0; g < NStg; g++) begin : g_dabble
    itoa_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dd_valid[g]),
      .ready_o (dd_ready[g]),
      .data_i  (dd_data[g]),
      .valid_o (dd_valid[g+1]),
      .ready_i (dd_ready[g+1]),
      .data_o  (dd_data[g+1])
    );
  end

  itoa_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dd_valid[NStg]),
    .ready_o (dd_ready[NStg]),
    .data_i  (dd_data[NStg]),
    .valid_o (dg_valid),
    .ready_i (dg_ready),
    .data_o  (dg_data)
  );

  // hold each request until its last character is taken
  itoa_serial u_serial (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (dg_valid),
    .ready_o   (dg_ready),
    .data_i    (dg_data),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_char_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o),
    .m_bad_o   (m_axis_tuser_o)
  );

endmodule

// ===== tb/itoa_checker.sv =====
// Checker that predicts and compares the character stream of the integer to ASCII converter.
`timescale 1ns / 1ps
module itoa_checker
  import itoa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,   // value[31:0], base[36:32], zero fill
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // char_out[7:0]
  input  logic        m_axis_tlast_i,
  input  logic        m_axis_tuser_i,   // bad_base[0]
  output int          err_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             bad;
  } ascii_beat_t;

  ascii_beat_t pending_chars_q[$];
  int          beat_cnt;

  initial err_cnt_o = 0;
  initial beat_cnt = 0;
  assign pending_o = pending_chars_q.size();

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR beat %0d: %s", $realtime, beat_cnt, msg);
    err_cnt_o++;
  endtask

  // Queue the characters one request should produce, most significant first.
  function automatic void predict_digits(input logic [ValueW-1:0] raw,
                                         input logic [BaseW-1:0] radix);
    logic [ValueW-1:0] mag;
    logic              neg;
    logic [3:0]        dig_q[$];
    logic [3:0]        d;
    ascii_beat_t       beat;
    if (radix != RADIX_BIN && radix != RADIX_OCT &&
        radix != RADIX_DEC && radix != RADIX_HEX) begin
      beat = '{ch: CH_NULL, last: 1'b1, bad: 1'b1};
      pending_chars_q.push_back(beat);
      return;
    end
    neg = (radix == RADIX_DEC) && raw[ValueW-1];
    mag = neg ? (~raw + 1'b1) : raw;
    // zero still yields a single digit
    do begin
      dig_q.push_front(4'(mag % {27'd0, radix}));
      mag = mag / {27'd0, radix};
    end while (mag != '0);
    if (neg) begin
      beat = '{ch: CH_MINUS, last: 1'b0, bad: 1'b0};
      pending_chars_q.push_back(beat);
    end
    for (int i = 0; i < dig_q.size(); i++) begin
      d = dig_q[i];
      beat.ch   = (d <= 4'd9) ? CH_DIGIT + CharW'(d) : CH_LETTER + CharW'(d);
      beat.last = (i == dig_q.size() - 1);
      beat.bad  = 1'b0;
      pending_chars_q.push_back(beat);
    end
  endfunction

  always @(posedge clk_i) begin
    ascii_beat_t exp_beat;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_digits(s_axis_tdata_i[ValueW-1:0], s_axis_tdata_i[ValueW +: BaseW]);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_chars_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h", m_axis_tdata_i));
        end else begin
          exp_beat = pending_chars_q.pop_front();
          if (m_axis_tdata_i !== exp_beat.ch)
            report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                      m_axis_tdata_i, exp_beat.ch));
          if (m_axis_tlast_i !== exp_beat.last)
            report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast_i, exp_beat.last));
          if (m_axis_tuser_i !== exp_beat.bad)
            report_mismatch($sformatf("bad_base %b, want %b",
                                      m_axis_tuser_i, exp_beat.bad));
        end
        beat_cnt++;
      end
    end
  end

endmodule

// ===== tb/tb_integer_to_ascii_radix.sv =====
// Testbench top for the integer to ASCII converter: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_integer_to_ascii_radix;
  import itoa_pkg::*;

  // Random part size; directed requests come on top of this.
  localparam int NumRandom = 240;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;        // value[31:0], base[36:32], zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;             // char_out[7:0]
  logic        m_axis_tlast;
  logic        m_axis_tuser;             // bad_base[0]
  int          err_cnt;
  int          pending;

  // Receiver stall state: a countdown of held-off cycles, plus calm stretches
  // where tready stays high so the serializer runs at full rate.
  int          hold_cnt = 0;
  int          calm_cnt = 150;
  logic        rx_calm = 1'b0;
  // Sender side: bursts of back-to-back requests with no gaps.
  logic        tx_burst = 1'b0;

  integer_to_ascii_radix dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  itoa_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .m_axis_tuser_i  (m_axis_tuser),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Drive tready on the master side: mostly short stalls, a few long ones,
  // and alternate with calm stretches of no stalls at all.
  always @(posedge clk_i) begin : rx_stall
    int r;
    r = $urandom_range(0, 15);
    if (calm_cnt == 0) begin
      rx_calm  <= ~rx_calm;
      calm_cnt <= $urandom_range(100, 400);
    end else begin
      calm_cnt <= calm_cnt - 1;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (rx_calm || r < 9) begin
      m_axis_tready <= 1'b1;
    end else if (r < 15) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= $urandom_range(8, 30);
    end
  end

  // Pick a sender gap: none in a burst, else none or short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (tx_burst || r < 8) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pick a value: full words, short magnitudes, small negatives and edges.
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      1: v = v >> $urandom_range(0, 31);
      2: v = ~(v >> $urandom_range(1, 31)) + 1'b1;
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // Pick a radix: mostly the four supported ones, sometimes any 5-bit code.
  function automatic logic [BaseW-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0, 1: return RADIX_BIN;
      2, 3: return RADIX_OCT;
      4, 5: return RADIX_DEC;
      6, 7: return RADIX_HEX;
      default: return BaseW'($urandom_range(0, 31));
    endcase
  endfunction

  // Hold the request until the converter takes it; drop valid only for a gap.
  task automatic send_request(input logic [ValueW-1:0] value,
                              input logic [BaseW-1:0] radix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {3'b000, radix, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero in every radix, all-ones, sign edges, octal inner zeros
    // and top digit, hex letters, and unsupported radix codes.
    send_request(32'h0000_0000, RADIX_BIN);
    send_request(32'h0000_0000, RADIX_OCT);
    send_request(32'h0000_0000, RADIX_DEC);
    send_request(32'h0000_0000, RADIX_HEX);
    send_request(32'hFFFF_FFFF, RADIX_BIN);
    send_request(32'hFFFF_FFFF, RADIX_OCT);
    send_request(32'hFFFF_FFFF, RADIX_DEC);
    send_request(32'hFFFF_FFFF, RADIX_HEX);
    send_request(32'h8000_0000, RADIX_DEC);
    send_request(32'h8000_0000, RADIX_OCT);
    send_request(32'h8000_0000, RADIX_BIN);
    send_request(32'h7FFF_FFFF, RADIX_DEC);
    send_request(32'h4000_0000, RADIX_OCT);
    send_request(32'h4000_0008, RADIX_OCT);
    send_request(32'hDEAD_BEEF, RADIX_HEX);
    send_request(32'h0ABC_DEF0, RADIX_HEX);
    send_request(32'h0000_0001, RADIX_DEC);
    send_request(32'h3B9A_CA00, RADIX_DEC);
    send_request(32'h1234_5678, 5'd0);
    send_request(32'h1234_5678, 5'd1);
    send_request(32'h0000_0000, 5'd9);
    send_request(32'hFFFF_FFFF, 5'd17);
    send_request(32'hA5A5_A5A5, 5'd31);

    // Random part: every third run of 32 requests goes back to back.
    for (int i = 0; i < NumRandom; i++) begin
      tx_burst = ((i / 32) % 3 == 1);
      send_request(pick_value(), pick_radix());
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker queue the last request, drain, then allow the
    // pipeline depth in case anything stray follows.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Slowest run is about 260 requests x 32 characters, each with the longest
  // receiver stall; allow about four times that.
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itoa_pkg.sv
rtl/itoa_front.sv
rtl/itoa_dabble.sv
rtl/itoa_digits.sv
rtl/itoa_serial.sv
rtl/integer_to_ascii_radix.sv
tb/itoa_checker.sv
tb/tb_integer_to_ascii_radix.sv
